// ===== rtl/integer_instruction_subset_execute_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the integer instruction subset execute block.
// Every macro samples on aclk and is disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH
`define INTEGER_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define IISE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IISE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iise_pkg.sv =====
// ---------------------------------------------------------------------------
// iise_pkg
// Types and constants shared by the front end, queue and back end.
// ---------------------------------------------------------------------------
package iise_pkg;

    localparam int REG_COUNT   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W  = 3;

    // Instruction format field, bits 27:26
    localparam logic [1:0] FMT_DP  = 2'd0;
    localparam logic [1:0] FMT_BR  = 2'd2;
    localparam logic [1:0] FMT_SWI = 2'd3;

    localparam logic [3:0]  MUL_MARK    = 4'b1001;
    localparam logic [7:0]  HALT_CODE   = 8'd10;
    localparam logic [31:0] BRANCH_BIAS = 32'd8;
    localparam logic [31:0] PC_STEP     = 32'd4;
    localparam logic [3:0]  LINK_REG    = 4'd14;

    // Register index of start_address on the config port
    localparam logic CFG_START_ADDRESS = 1'b0;

    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_DP,
        CLS_MUL,
        CLS_BR,
        CLS_SWI
    } cls_t;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_ADD = 4'd4,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    typedef enum logic [1:0] {
        SH_LSL,
        SH_LSR,
        SH_ASR,
        SH_ROR
    } shift_t;

    // Decoded instruction as it travels from front to back
    typedef struct packed {
        cls_t        cls;
        alu_op_t     alu;
        logic        acc;       // MLA
        logic        use_imm;   // operand two from konst
        shift_t      sh_kind;
        logic [4:0]  sh_amt;
        logic [3:0]  rd;
        logic [3:0]  rm;
        logic [3:0]  rs;
        logic [3:0]  rn;
        logic        link;      // BL
        logic [31:0] konst;     // rotated immediate or branch offset with bias
    } uop_t;

    typedef struct packed {
        logic        load;
        logic [31:0] pc;
    } pc_load_t;

endpackage

// ===== rtl/iise_front.sv =====
// ---------------------------------------------------------------------------
// iise_front
// Accepts instruction beats and classifies them into decoded micro-ops.
// ---------------------------------------------------------------------------
module iise_front
    import iise_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction_word,
    output logic        push_valid,
    input  logic        push_ready,
    output uop_t        push_uop
);

    logic [31:0] w;
    logic [63:0] imm_pair;
    logic [31:0] br_off;

    assign w          = s_instruction_word;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // Immediate rotated right by twice the rotate field
    assign imm_pair = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
    // Sign-extended word offset plus pipeline bias
    assign br_off   = {{6{w[23]}}, w[23:0], 2'b00} + BRANCH_BIAS;

    always_comb begin
        push_uop         = '0;
        push_uop.cls     = CLS_NOP;
        push_uop.alu     = OP_AND;
        push_uop.sh_kind = shift_t'(w[6:5]);
        push_uop.sh_amt  = w[11:7];
        push_uop.rm      = w[3:0];
        case (w[27:26])
            FMT_DP: begin
                if (w[25:22] == 4'd0 && w[7:4] == MUL_MARK) begin
                    push_uop.cls = CLS_MUL;
                    push_uop.acc = w[21];
                    push_uop.rd  = w[19:16];
                    push_uop.rn  = w[15:12];
                    push_uop.rs  = w[11:8];
                end else begin
                    if (w[24:21] inside {OP_AND, OP_EOR, OP_SUB, OP_ADD,
                                         OP_ORR, OP_MOV, OP_BIC, OP_MVN}) begin
                        push_uop.cls = CLS_DP;
                    end
                    push_uop.alu     = alu_op_t'(w[24:21]);
                    push_uop.use_imm = w[25];
                    push_uop.konst   = imm_pair[31:0];
                    push_uop.rd      = w[15:12];
                    push_uop.rn      = w[19:16];
                end
            end
            FMT_BR: begin
                push_uop.cls   = CLS_BR;
                push_uop.link  = w[24];
                push_uop.konst = br_off;
            end
            FMT_SWI: begin
                if (w[7:0] == HALT_CODE) begin
                    push_uop.cls = CLS_SWI;
                end
            end
            default: begin
                push_uop.cls = CLS_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/iise_queue.sv =====
// ---------------------------------------------------------------------------
// iise_queue
// Short FIFO of decoded micro-ops between front and back.
// ---------------------------------------------------------------------------
module iise_queue
    import iise_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  uop_t push_uop,
    output logic pop_valid,
    input  logic pop_ready,
    output uop_t pop_uop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    uop_t             ent_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_uop    = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_uop;
        end
    end

endmodule

// ===== rtl/iise_back.sv =====
// ---------------------------------------------------------------------------
// iise_back
// Executes micro-ops against the register file and program counter.
// ---------------------------------------------------------------------------
module iise_back
    import iise_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pc_load_t    pc_load,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  uop_t        pop_uop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_write,
    output logic [3:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic        m_halted
);

    // Register file: two banks written together; bank_a serves Rm and Rs,
    // bank_b serves Rn
    logic [31:0]          bank_a [REG_COUNT];
    logic [31:0]          bank_b [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;

    logic        ex_v_reg;
    uop_t        ex_uop_reg;
    logic [31:0] rd_m_reg, rd_s_reg, rd_n_reg;
    logic        vld_m_reg, vld_s_reg, vld_n_reg;
    logic        lw_v_reg;
    logic [3:0]  lw_idx_reg;
    logic [31:0] lw_val_reg;
    logic [31:0] pc_reg;
    logic        stopped_reg;

    logic        out_v_reg;
    logic [31:0] out_pc_reg;
    logic        out_wr_reg;
    logic [3:0]  out_idx_reg;
    logic [31:0] out_val_reg;
    logic        out_halt_reg;

    logic        ex_fire, ex_load;
    logic [3:0]  addr_m, addr_s, addr_n;
    logic [31:0] op_m, op_s, op_n;
    logic [31:0] prod;
    logic [63:0] ror_pair;
    logic [31:0] shifted, op_b, alu_res;
    logic [31:0] pc_plus4;
    logic        res_wr;
    logic [3:0]  res_idx;
    logic [31:0] res_val;
    logic [31:0] pc_next;
    logic        stopped_next;

    assign ex_fire   = ex_v_reg && (!out_v_reg || m_ready);
    assign pop_ready = !ex_v_reg || ex_fire;
    assign ex_load   = pop_valid && pop_ready;

    // Read for the incoming op, else refresh the op held in execute
    assign addr_m = ex_load ? pop_uop.rm : ex_uop_reg.rm;
    assign addr_s = ex_load ? pop_uop.rs : ex_uop_reg.rs;
    assign addr_n = ex_load ? pop_uop.rn : ex_uop_reg.rn;

    always_ff @(posedge aclk) begin
        rd_m_reg  <= bank_a[addr_m];
        rd_s_reg  <= bank_a[addr_s];
        rd_n_reg  <= bank_b[addr_n];
        vld_m_reg <= rf_vld_reg[addr_m];
        vld_s_reg <= rf_vld_reg[addr_s];
        vld_n_reg <= rf_vld_reg[addr_n];
        if (ex_fire && res_wr) begin
            bank_a[res_idx] <= res_val;
            bank_b[res_idx] <= res_val;
        end
    end

    // Bypass the write made at the same edge the read data was taken
    assign op_m = (lw_v_reg && lw_idx_reg == ex_uop_reg.rm) ? lw_val_reg
                : (vld_m_reg ? rd_m_reg : '0);
    assign op_s = (lw_v_reg && lw_idx_reg == ex_uop_reg.rs) ? lw_val_reg
                : (vld_s_reg ? rd_s_reg : '0);
    assign op_n = (lw_v_reg && lw_idx_reg == ex_uop_reg.rn) ? lw_val_reg
                : (vld_n_reg ? rd_n_reg : '0);

    assign prod     = op_m * op_s;
    assign ror_pair = {op_m, op_m} >> ex_uop_reg.sh_amt;
    assign pc_plus4 = pc_reg + PC_STEP;

    // A zero amount leaves Rm unchanged for every shift type
    always_comb begin
        case (ex_uop_reg.sh_kind)
            SH_LSL:  shifted = op_m << ex_uop_reg.sh_amt;
            SH_LSR:  shifted = op_m >> ex_uop_reg.sh_amt;
            SH_ASR:  shifted = 32'($signed(op_m) >>> ex_uop_reg.sh_amt);
            SH_ROR:  shifted = ror_pair[31:0];
            default: shifted = op_m;
        endcase
    end

    assign op_b = ex_uop_reg.use_imm ? ex_uop_reg.konst : shifted;

    always_comb begin
        case (ex_uop_reg.alu)
            OP_AND:  alu_res = op_n & op_b;
            OP_EOR:  alu_res = op_n ^ op_b;
            OP_SUB:  alu_res = op_n - op_b;
            OP_ADD:  alu_res = op_n + op_b;
            OP_ORR:  alu_res = op_n | op_b;
            OP_MOV:  alu_res = op_b;
            OP_BIC:  alu_res = op_n & ~op_b;
            OP_MVN:  alu_res = ~op_b;
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        res_wr       = 1'b0;
        res_idx      = '0;
        res_val      = '0;
        pc_next      = pc_plus4;
        stopped_next = stopped_reg;
        if (stopped_reg) begin
            pc_next = pc_reg;
        end else begin
            case (ex_uop_reg.cls)
                CLS_MUL: begin
                    res_wr  = 1'b1;
                    res_idx = ex_uop_reg.rd;
                    res_val = prod + (ex_uop_reg.acc ? op_n : '0);
                end
                CLS_DP: begin
                    res_wr  = 1'b1;
                    res_idx = ex_uop_reg.rd;
                    res_val = alu_res;
                end
                CLS_BR: begin
                    pc_next = pc_reg + ex_uop_reg.konst;
                    if (ex_uop_reg.link) begin
                        res_wr  = 1'b1;
                        res_idx = LINK_REG;
                        res_val = pc_plus4;
                    end
                end
                CLS_SWI: begin
                    stopped_next = 1'b1;
                end
                default: begin
                    res_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_v_reg    <= 1'b0;
            lw_v_reg    <= 1'b0;
            rf_vld_reg  <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            if (ex_load) begin
                ex_v_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_v_reg <= 1'b0;
            end
            lw_v_reg <= ex_fire && res_wr;
            if (ex_fire && res_wr) begin
                rf_vld_reg[res_idx] <= 1'b1;
            end
            if (pc_load.load) begin
                pc_reg <= pc_load.pc;
            end else if (ex_fire) begin
                pc_reg <= pc_next;
            end
            if (ex_fire) begin
                stopped_reg <= stopped_next;
                out_v_reg   <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_load) begin
            ex_uop_reg <= pop_uop;
        end
        lw_idx_reg <= res_idx;
        lw_val_reg <= res_val;
        if (ex_fire) begin
            out_pc_reg   <= pc_next;
            out_wr_reg   <= res_wr;
            out_idx_reg  <= res_idx;
            out_val_reg  <= res_val;
            out_halt_reg <= stopped_next;
        end
    end

    assign m_valid     = out_v_reg;
    assign m_next_pc   = out_pc_reg;
    assign m_reg_write = out_wr_reg;
    assign m_reg_index = out_idx_reg;
    assign m_reg_value = out_val_reg;
    assign m_halted    = out_halt_reg;

endmodule

// ===== rtl/integer_instruction_subset_execute.sv =====
// ---------------------------------------------------------------------------
// integer_instruction_subset_execute
// Executes one 32-bit integer instruction per beat against sixteen
// registers and a program counter, and reports the resulting write.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one instruction word per beat, fetched at the PC
//   that the previous result reported. m_ channel returns exactly one
//   result beat per instruction: next PC, register write, halt status.
//   APB port holds start_address at offset 0; a write also loads the PC.
//   Write it only while no instruction is in flight.
// Timing:
//   Results pass the decode queue, execute and result registers in order.
//   While m_ready is high, throughput is one instruction per cycle; the
//   execute stage (operand bypass, 32x32 multiplier and accumulate adder)
//   sets the clock rate. Reads use the previous instruction's write by bypass.
// Reset:
//   Synchronous, active low. Clears the register file valid bits (all
//   registers read zero), loads the PC and start_address with zero and
//   releases the halt.
// Backpressure:
//   A held m_ beat stalls execute; the two-entry decode queue keeps
//   accepting until full, then s_ready drops.
// ---------------------------------------------------------------------------
module integer_instruction_subset_execute
    import iise_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Instruction channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_instruction_word,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_next_pc,
    output logic                  m_reg_write,
    output logic [3:0]            m_reg_index,
    output logic [31:0]           m_reg_value,
    output logic                  m_halted
);

    logic [31:0] start_addr_reg;
    logic        cfg_wr;
    logic        cfg_hit;
    pc_load_t    pc_load;

    logic        push_valid, push_ready;
    uop_t        push_uop;
    logic        pop_valid, pop_ready;
    uop_t        pop_uop;

    // APB: zero wait states, word registers decoded above the byte lane bits
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_START_ADDRESS);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? start_addr_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= '0;
        end else if (cfg_wr) begin
            start_addr_reg <= pwdata;
        end
    end

    // Load the PC along with start_address
    assign pc_load.load = cfg_wr;
    assign pc_load.pc   = pwdata;

    iise_front u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_instruction_word (s_instruction_word),
        .push_valid         (push_valid),
        .push_ready         (push_ready),
        .push_uop           (push_uop)
    );

    iise_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_uop   (push_uop),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_uop    (pop_uop)
    );

    iise_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pc_load     (pc_load),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_uop     (pop_uop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_next_pc   (m_next_pc),
        .m_reg_write (m_reg_write),
        .m_reg_index (m_reg_index),
        .m_reg_value (m_reg_value),
        .m_halted    (m_halted)
    );

endmodule

// ===== rtl/iise_checker.sv =====
// ---------------------------------------------------------------------------
// iise_checker
// Port-level checks for the execute block, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_instruction_subset_execute_defines.svh"

module iise_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_next_pc,
    input logic        m_reg_write,
    input logic [31:0] m_reg_value,
    input logic        m_halted
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       halted_seen_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + 3'd1;
        end else if (out_beat && !in_beat) begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg        <= '0;
            halted_seen_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (out_beat && m_halted) begin
                halted_seen_reg <= 1'b1;
            end
        end
    end

    `IISE_ASSERT_IMP(a_no_phantom_result, m_valid, pend_reg != 3'd0, "result without instruction")
    `IISE_ASSERT_IMP(a_inflight_bound, pend_reg == 3'd4, !s_ready, "more than four in flight")
    `IISE_ASSERT_IMP(a_halt_sticky, m_valid && halted_seen_reg, m_halted && !m_reg_write, "halt lost")
    `IISE_ASSERT_NXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_next_pc) && $stable(m_reg_value), "stalled result changed")

endmodule

bind integer_instruction_subset_execute iise_checker u_iise_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_next_pc   (m_next_pc),
    .m_reg_write (m_reg_write),
    .m_reg_value (m_reg_value),
    .m_halted    (m_halted)
);

// ===== test/integer_instruction_subset_execute_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_instruction_subset_execute_tb
// Self-checking bench for the integer instruction subset execute block.
// Drives instruction beats and APB writes of the start address, mirrors
// the register file, program counter and halt state in a tracker class,
// and compares every result beat, field by field, against the oldest
// predicted beat. Runs a directed opening, three random phases with
// different idle profiles, and ends with a halt followed by ignored words.
// ----------------------------------------------------------------------------
module integer_instruction_subset_execute_tb;
    import iise_pkg::*;

    localparam int          CYCLE_LIMIT       = 400000;
    localparam int          WORDS_PER_PHASE   = 360;
    localparam int          LONG_HOLD_CYCLES  = 64;
    localparam int          REPORT_LIMIT      = 10;
    localparam int          DRAIN_CYCLES      = 8;
    localparam logic [3:0]  COND_AL           = 4'hE;
    localparam logic [1:0]  FMT_XFER          = 2'd1;

    // Opcodes the block leaves unexecuted
    localparam logic [3:0]  OPC_RSB = 4'd3;
    localparam logic [3:0]  OPC_ADC = 4'd5;
    localparam logic [3:0]  OPC_TST = 4'd8;
    localparam logic [3:0]  OPC_CMP = 4'd10;
    localparam logic [3:0]  OPC_CMN = 4'd11;

    localparam logic [CFG_ADDR_W-1:0] START_ADDR_OFFSET = CFG_ADDR_W'(4 * CFG_START_ADDRESS);

    localparam alu_op_t LIVE_OPS [8] = '{OP_AND, OP_EOR, OP_SUB, OP_ADD,
                                         OP_ORR, OP_MOV, OP_BIC, OP_MVN};

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        halted;
    } exec_result_t;

    // ------------------------------------------------------------------
    // Architectural state mirror: predicts one result beat per word and
    // holds the predictions until the block delivers them.
    // ------------------------------------------------------------------
    class core_state_tracker;
        logic [31:0]  arch_regs [16];
        logic [31:0]  pc;
        bit           stopped;
        exec_result_t pending_results [$];
        int unsigned  mismatches;

        function new();
            foreach (arch_regs[i]) arch_regs[i] = '0;
            pc         = '0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        // A start address write also reloads the program counter.
        function void load_start(logic [31:0] addr);
            pc = addr;
        endfunction

        function logic [31:0] rotate_right(logic [31:0] v, logic [4:0] n);
            if (n == 5'd0)
                return v;
            return (v >> n) | (v << (6'd32 - n));
        endfunction

        function void retire_word(logic [31:0] w);
            exec_result_t r;
            logic [31:0]  a;
            logic [31:0]  b;
            logic [31:0]  rm_val;
            logic [31:0]  offset;
            logic [4:0]   amt;
            r         = '0;
            r.next_pc = pc + PC_STEP;
            if (stopped) begin
                // Halted: ignore the word, hold the PC
                r.next_pc = pc;
            end else if (w[27:26] == FMT_DP) begin
                if (w[25:22] == 4'd0 && w[7:4] == MUL_MARK) begin
                    // Multiply wins over data processing
                    r.reg_value = arch_regs[w[3:0]] * arch_regs[w[11:8]];
                    if (w[21])
                        r.reg_value = r.reg_value + arch_regs[w[15:12]];
                    r.reg_write = 1'b1;
                    r.reg_index = w[19:16];
                end else begin
                    a = arch_regs[w[19:16]];
                    if (w[25]) begin
                        b = rotate_right({24'd0, w[7:0]}, {w[11:8], 1'b0});
                    end else begin
                        // Amount zero passes Rm through for every shift type
                        rm_val = arch_regs[w[3:0]];
                        amt    = w[11:7];
                        if (amt == 5'd0)
                            b = rm_val;
                        else case (w[6:5])
                            SH_LSL:  b = rm_val << amt;
                            SH_LSR:  b = rm_val >> amt;
                            SH_ASR:  b = $unsigned($signed(rm_val) >>> amt);
                            default: b = rotate_right(rm_val, amt);
                        endcase
                    end
                    r.reg_write = 1'b1;
                    case (w[24:21])
                        OP_AND:  r.reg_value = a & b;
                        OP_EOR:  r.reg_value = a ^ b;
                        OP_SUB:  r.reg_value = a - b;
                        OP_ADD:  r.reg_value = a + b;
                        OP_ORR:  r.reg_value = a | b;
                        OP_MOV:  r.reg_value = b;
                        OP_BIC:  r.reg_value = a & ~b;
                        OP_MVN:  r.reg_value = ~b;
                        default: r.reg_write = 1'b0;
                    endcase
                    if (r.reg_write)
                        r.reg_index = w[15:12];
                end
            end else if (w[27:26] == FMT_BR) begin
                offset = {{6{w[23]}}, w[23:0], 2'b00};
                if (w[24]) begin
                    r.reg_write = 1'b1;
                    r.reg_index = LINK_REG;
                    r.reg_value = pc + PC_STEP;
                end
                r.next_pc = pc + offset + BRANCH_BIAS;
            end else if (w[27:26] == FMT_SWI && w[7:0] == HALT_CODE) begin
                stopped = 1'b1;
            end
            if (r.reg_write)
                arch_regs[r.reg_index] = r.reg_value;
            pc       = r.next_pc;
            r.halted = stopped;
            pending_results.push_back(r);
        endfunction

        function void match_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result beat with nothing pending: pc=%h wr=%b idx=%0d val=%h h=%b",
                             $time, got.next_pc, got.reg_write, got.reg_index, got.reg_value,
                             got.halted);
                return;
            end
            want = pending_results.pop_front();
            if (got.next_pc !== want.next_pc || got.reg_write !== want.reg_write ||
                got.reg_index !== want.reg_index || got.reg_value !== want.reg_value ||
                got.halted !== want.halted) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] result mismatch", $time);
                    $display("  expected pc=%h wr=%b idx=%0d val=%h h=%b", want.next_pc,
                             want.reg_write, want.reg_index, want.reg_value, want.halted);
                    $display("  actual   pc=%h wr=%b idx=%0d val=%h h=%b", got.next_pc,
                             got.reg_write, got.reg_index, got.reg_value, got.halted);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [31:0]           s_instruction_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [31:0]           m_next_pc;
    logic                  m_reg_write;
    logic [3:0]            m_reg_index;
    logic [31:0]           m_reg_value;
    logic                  m_halted;

    core_state_tracker tracker;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       hold_requests;
    int unsigned       hold_served;
    int unsigned       config_read_errors;
    int unsigned       cycle_count;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    integer_instruction_subset_execute u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_instruction_word (s_instruction_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_next_pc          (m_next_pc),
        .m_reg_write        (m_reg_write),
        .m_reg_index        (m_reg_index),
        .m_reg_value        (m_reg_value),
        .m_halted           (m_halted)
    );

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------
    function automatic logic [31:0] dp_imm(logic [3:0] op, logic [3:0] rn, logic [3:0] rd,
                                           logic [3:0] rot, logic [7:0] imm);
        return {COND_AL, FMT_DP, 1'b1, op, 1'b0, rn, rd, rot, imm};
    endfunction

    // reg_shift sets bit 4, which the block must ignore
    function automatic logic [31:0] dp_reg(logic [3:0] op, logic [3:0] rn, logic [3:0] rd,
                                           logic [4:0] amt, shift_t kind, logic reg_shift,
                                           logic [3:0] rm);
        return {COND_AL, FMT_DP, 1'b0, op, 1'b0, rn, rd, amt, kind, reg_shift, rm};
    endfunction

    function automatic logic [31:0] mul_word(logic acc, logic [3:0] rd, logic [3:0] rn,
                                             logic [3:0] rs, logic [3:0] rm);
        return {COND_AL, 6'b000000, acc, 1'b0, rd, rn, rs, MUL_MARK, rm};
    endfunction

    function automatic logic [31:0] br_word(logic link, logic [23:0] offset);
        return {COND_AL, FMT_BR, 1'b1, link, offset};
    endfunction

    function automatic logic [31:0] swi_word(logic [7:0] code);
        return {COND_AL, FMT_SWI, 2'b11, 16'h0000, code};
    endfunction

    // Favor low registers so back-to-back words often depend on each other
    function automatic logic [3:0] pick_reg();
        return ($urandom_range(1) != 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    endfunction

    function automatic logic [3:0] pick_op();
        return ($urandom_range(4) != 0) ? LIVE_OPS[$urandom_range(7)] : 4'($urandom);
    endfunction

    // Mostly well-formed words with random content, 22 percent raw noise.
    // Never produce the halt code here: it would freeze the rest of the run.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            w = dp_reg(pick_op(), pick_reg(), pick_reg(), 5'($urandom),
                       shift_t'($urandom_range(3)), 1'($urandom), pick_reg());
        else if (pick < 50)
            w = dp_imm(pick_op(), pick_reg(), pick_reg(), 4'($urandom), 8'($urandom));
        else if (pick < 65)
            w = mul_word(1'($urandom), pick_reg(), pick_reg(), pick_reg(), pick_reg());
        else if (pick < 78)
            w = br_word(1'($urandom), ($urandom_range(1) != 0) ? 24'($urandom)
                                      : {{16{1'($urandom)}}, 8'($urandom)});
        else
            w = $urandom;
        if (pick < 78)
            w[31:28] = 4'($urandom);
        if (w[27:26] == FMT_SWI && w[7:0] == HALT_CODE)
            w[0] = ~w[0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: everything changes at the falling edge
    // ------------------------------------------------------------------

    // Offer one instruction beat; hold it until accepted. Returns at the
    // falling edge after the accepting edge with s_valid still high, so
    // the next beat can follow without a bubble.
    task automatic send_word(input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_instruction_word <= word;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending_results.size() != 0);
    endtask

    // APB write of start_address, then read it back. Call only while idle.
    task automatic program_start_address(input logic [31:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_ADDR_OFFSET;
        pwdata  <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== addr) begin
            config_read_errors++;
            $display("[%0t] start_address readback: expected %h, got %h", $time, addr, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.load_start(addr);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus long hold-offs on request so the
    // decode queue fills and s_ready drops while the sender keeps going.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted instruction beat, then check each
    // accepted result beat. Sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : beat_monitor
        exec_result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.retire_word(s_instruction_word);
            if (m_valid && m_ready) begin
                seen.next_pc   = m_next_pc;
                seen.reg_write = m_reg_write;
                seen.reg_index = m_reg_index;
                seen.reg_value = m_reg_value;
                seen.halted    = m_halted;
                tracker.match_result(seen);
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] phase_start;
        aresetn            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        s_valid            = 1'b0;
        s_instruction_word = '0;
        send_idle_pct      = 37;
        recv_idle_pct      = 46;
        hold_requests      = 0;
        hold_served        = 0;
        config_read_errors = 0;
        tracker            = new();

        // Hold reset low, then release it at a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening. Start near the top of the address space so
        // PC+4 and branch targets wrap.
        program_start_address(32'hFFFF_FFF8);
        send_word(dp_imm(OP_MOV, 4'd0, 4'd1, 4'd0, 8'hFF));
        send_word(dp_imm(OP_MVN, 4'd0, 4'd2, 4'hF, 8'h81));
        send_word(dp_imm(OP_ADD, 4'd1, 4'd3, 4'd1, 8'h00));
        // Shift amount zero: Rm passes unchanged
        send_word(dp_reg(OP_SUB, 4'd0, 4'd4, 5'd0, SH_LSL, 1'b0, 4'd1));
        send_word(dp_reg(OP_ADD, 4'd4, 4'd5, 5'd31, SH_LSL, 1'b0, 4'd2));
        send_word(dp_reg(OP_EOR, 4'd4, 4'd6, 5'd31, SH_LSR, 1'b0, 4'd4));
        send_word(dp_reg(OP_ORR, 4'd1, 4'd7, 5'd4, SH_ASR, 1'b0, 4'd4));
        send_word(dp_reg(OP_AND, 4'd4, 4'd8, 5'd0, SH_ASR, 1'b0, 4'd2));
        send_word(dp_reg(OP_BIC, 4'd4, 4'd9, 5'd8, SH_ROR, 1'b0, 4'd1));
        // R15 is an ordinary register, separate from the PC
        send_word(dp_reg(OP_MOV, 4'd0, 4'd15, 5'd31, SH_ROR, 1'b0, 4'd4));
        // Register-specified shift: bit 4 ignored, amount from bits 11:7
        send_word(dp_reg(OP_MVN, 4'd0, 4'd10, 5'd3, SH_LSR, 1'b1, 4'd15));
        // Bits 7:4 read 1001 but the opcode keeps it data processing
        send_word(dp_reg(OP_ADD, 4'd4, 4'd11, 5'd1, SH_LSL, 1'b1, 4'd7));
        send_word(mul_word(1'b0, 4'd12, 4'd0, 4'd7, 4'd4));
        send_word(mul_word(1'b1, 4'd13, 4'd5, 4'd2, 4'd15));
        // Unexecuted opcodes and the transfer format write nothing
        send_word(dp_imm(OPC_RSB, 4'd1, 4'd3, 4'd0, 8'h01));
        send_word(dp_reg(OPC_ADC, 4'd1, 4'd3, 5'd2, SH_LSL, 1'b0, 4'd4));
        send_word(dp_reg(OPC_TST, 4'd4, 4'd0, 5'd0, SH_LSL, 1'b0, 4'd4));
        send_word(dp_imm(OPC_CMP, 4'd4, 4'd0, 4'd0, 8'h00));
        send_word(dp_imm(OPC_CMN, 4'd4, 4'd0, 4'd0, 8'h00));
        send_word({COND_AL, FMT_XFER, 26'h3FF_FFFF});
        // Branch offset extremes, link, and a branch to itself
        send_word(br_word(1'b0, 24'h7F_FFFF));
        send_word(br_word(1'b1, 24'h80_0000));
        send_word(br_word(1'b1, 24'hFF_FFFE));
        // Software interrupts with codes other than halt do nothing
        send_word(swi_word(8'hFF));
        send_word(swi_word(8'd11));

        // Random phases: receiver-heavy idling, sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0:       phase_start = 32'h0000_0000;
                1:       phase_start = 32'hFFFF_FFFF;
                default: phase_start = $urandom;
            endcase
            program_start_address(phase_start);
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // Long receiver hold-off while beats keep coming
                if ((phase == 2 && k == 40) || (phase == 0 && k == 200))
                    hold_requests++;
                // Pause the sender until the pipeline is empty
                if (phase == 1 && k == 180)
                    wait_drained();
                send_word(random_word());
            end
        end

        // Halt, then words the block must ignore
        send_word(swi_word(HALT_CODE));
        for (int k = 0; k < 10; k++)
            send_word(random_word());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0 &&
            config_read_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
